// File: design/tpts_pkg.sv
`default_nettype none
package tpts_pkg;

  localparam int TASK_SLOTS = 4;
  localparam int SLOT_W     = 2;
  localparam int LEVEL_W    = 3;
  localparam int CNT_W      = 16;
  localparam int KIND_W     = 2;
  localparam int QDEPTH     = 2;

  localparam logic [LEVEL_W-1:0] IDLE_LVL = LEVEL_W'(TASK_SLOTS);

  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  typedef enum logic [3:0] {
    OP_ADD  = 4'b0001,
    OP_TICK = 4'b0010,
    OP_DONE = 4'b0100,
    OP_NOP  = 4'b1000
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [CNT_W-1:0]   period;
    logic [CNT_W-1:0]   first_delay;
  } cmd_t;

  typedef struct packed {
    logic              add_ok;
    logic [SLOT_W-1:0] slot;
    logic              started;
    logic [SLOT_W-1:0] start_task;
    logic              finished;
    logic [SLOT_W-1:0] finished_task;
    logic              removed;
    logic              fault;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_START = 4'b0100,
    ST_OUT   = 4'b1000
  } back_state_t;

endpackage
`default_nettype wire

// File: design/tpts_front.sv
`default_nettype none
module tpts_front import tpts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [CNT_W-1:0]  in_period,
  input  wire logic [CNT_W-1:0]  in_first_delay,
  output logic                   q_valid,
  output cmd_t                   q_cmd,
  input  wire logic              q_pop
);

  localparam logic [1:0] QCNT = 2'(QDEPTH);

  cmd_t       mem_r [QDEPTH];
  cmd_t       cmd;
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  always_comb begin
    cmd.period      = in_period;
    cmd.first_delay = in_first_delay;
    case (in_kind)
      KIND_ADD:  cmd.op = OP_ADD;
      KIND_TICK: cmd.op = OP_TICK;
      KIND_DONE: cmd.op = OP_DONE;
      default:   cmd.op = OP_NOP;
    endcase
  end

  assign in_stall = (count_r == QCNT);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT) else $error("queue count overflow");
`endif

endmodule
`default_nettype wire

// File: design/tpts_back.sv
`default_nettype none
module tpts_back import tpts_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire cmd_t               q_cmd,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_add_ok,
  output logic [SLOT_W-1:0]       out_slot,
  output logic                    out_started,
  output logic [SLOT_W-1:0]       out_start_task,
  output logic                    out_finished,
  output logic [SLOT_W-1:0]       out_finished_task,
  output logic                    out_removed,
  output logic                    out_fault,
  output logic [LEVEL_W-1:0]      out_running_level
);

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r;

  logic [TASK_SLOTS-1:0] valid_r, valid_nxt;
  logic [TASK_SLOTS-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0]      period_r [TASK_SLOTS];
  logic [CNT_W-1:0]      period_nxt [TASK_SLOTS];
  logic [CNT_W-1:0]      cd_r [TASK_SLOTS];
  logic [CNT_W-1:0]      cd_nxt [TASK_SLOTS];
  logic [LEVEL_W-1:0]    saved_r [TASK_SLOTS];
  logic [LEVEL_W-1:0]    level_r, level_nxt;
  logic [LEVEL_W-1:0]    depth_r, depth_nxt;
  logic [LEVEL_W-1:0]    depth_dec, saved_top;
  logic                  push_en;
  logic                  go_r, go_nxt;
  res_t                  work_r, work_nxt;
  res_t                  res_r;
  logic [LEVEL_W-1:0]    lvl_out_r;
  logic                  out_valid_r, out_valid_nxt, out_load;
  logic                  found;
  logic [SLOT_W-1:0]     cur_slot;

  assign q_pop     = q_valid && (state_r == ST_IDLE);
  assign depth_dec = depth_r - LEVEL_W'(1);
  assign saved_top = saved_r[depth_dec[SLOT_W-1:0]];
  assign cur_slot  = level_r[SLOT_W-1:0];
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    pend_nxt   = pend_r;
    period_nxt = period_r;
    cd_nxt     = cd_r;
    level_nxt  = level_r;
    depth_nxt  = depth_r;
    go_nxt     = go_r;
    work_nxt   = work_r;
    push_en    = 1'b0;
    found      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_EXEC;
          work_nxt  = '0;
          go_nxt    = 1'b0;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_START;
        case (cmd_r.op)
          OP_ADD: begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
              if (!found && !valid_r[i]) begin
                found               = 1'b1;
                valid_nxt[i]        = 1'b1;
                pend_nxt[i]         = 1'b0;
                period_nxt[i]       = cmd_r.period;
                cd_nxt[i]           = cmd_r.first_delay;
                work_nxt.add_ok     = 1'b1;
                work_nxt.slot       = SLOT_W'(i);
              end
            end
          end
          OP_TICK: begin
            go_nxt = 1'b1;
            for (int i = 0; i < TASK_SLOTS; i++) begin
              if (valid_r[i]) begin
                if (cd_r[i] != '0) begin
                  cd_nxt[i] = cd_r[i] - CNT_W'(1);
                end else begin
                  pend_nxt[i] = 1'b1;
                  cd_nxt[i]   = (period_r[i] != '0) ? period_r[i] - CNT_W'(1) : '0;
                end
              end
            end
          end
          OP_DONE: begin
            if (depth_r == '0 || level_r >= IDLE_LVL) begin
              work_nxt.fault = 1'b1;
            end else begin
              go_nxt                 = 1'b1;
              work_nxt.finished      = 1'b1;
              work_nxt.finished_task = cur_slot;
              depth_nxt              = depth_dec;
              level_nxt              = (saved_top > IDLE_LVL) ? IDLE_LVL : saved_top;
              if (period_r[cur_slot] == '0) begin
                valid_nxt[cur_slot] = 1'b0;
                pend_nxt[cur_slot]  = 1'b0;
                work_nxt.removed    = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_START: begin
        state_nxt = ST_OUT;
        if (go_r && depth_r < IDLE_LVL) begin
          for (int i = 0; i < TASK_SLOTS; i++) begin
            if (!found && LEVEL_W'(i) < level_r && valid_r[i] && pend_r[i]) begin
              found               = 1'b1;
              pend_nxt[i]         = 1'b0;
              push_en             = 1'b1;
              depth_nxt           = depth_r + LEVEL_W'(1);
              level_nxt           = LEVEL_W'(i);
              work_nxt.started    = 1'b1;
              work_nxt.start_task = SLOT_W'(i);
            end
          end
        end
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      pend_r      <= '0;
      level_r     <= IDLE_LVL;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      level_r     <= level_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    cd_r     <= cd_nxt;
    go_r     <= go_nxt;
    work_r   <= work_nxt;
    if (q_pop) cmd_r <= q_cmd;
    if (push_en) saved_r[depth_r[SLOT_W-1:0]] <= level_r;
    if (out_load) begin
      res_r     <= work_r;
      lvl_out_r <= level_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_add_ok        = res_r.add_ok;
  assign out_slot          = res_r.slot;
  assign out_started       = res_r.started;
  assign out_start_task    = res_r.start_task;
  assign out_finished      = res_r.finished;
  assign out_finished_task = res_r.finished_task;
  assign out_removed       = res_r.removed;
  assign out_fault         = res_r.fault;
  assign out_running_level = lvl_out_r;

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r == '0) == (level_r == IDLE_LVL)) else $error("level and stack disagree");
  a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & ~valid_r) == '0) else $error("pending mark on free slot");
  a_start_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && work_r.started |=> out_running_level == {1'b0, out_start_task})
    else $error("started task is not the running level");
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= IDLE_LVL) else $error("stack overflow");
`endif

endmodule
`default_nettype wire

// File: design/tick_priority_task_scheduler.sv
// A beat accepted on the input is queued, then handled by the back-end
// sequencer (fetch, execute, start search, result load) one item at a time:
// a new item is fetched only once the last result is loaded. A 2-entry
// queue decouples input.
// Reset (synchronous): table empty, nothing pending, idle level, stack empty,
// queue empty, no result waiting.
`default_nettype none
module tick_priority_task_scheduler import tpts_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [CNT_W-1:0]   in_period,
  input  wire logic [CNT_W-1:0]   in_first_delay,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_add_ok,
  output logic [SLOT_W-1:0]       out_slot,
  output logic                    out_started,
  output logic [SLOT_W-1:0]       out_start_task,
  output logic                    out_finished,
  output logic [SLOT_W-1:0]       out_finished_task,
  output logic                    out_removed,
  output logic                    out_fault,
  output logic [LEVEL_W-1:0]      out_running_level
);

  logic q_valid, q_pop;
  cmd_t q_cmd;

  tpts_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_period      (in_period),
    .in_first_delay (in_first_delay),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  tpts_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_add_ok        (out_add_ok),
    .out_slot          (out_slot),
    .out_started       (out_started),
    .out_start_task    (out_start_task),
    .out_finished      (out_finished),
    .out_finished_task (out_finished_task),
    .out_removed       (out_removed),
    .out_fault         (out_fault),
    .out_running_level (out_running_level)
  );

endmodule
`default_nettype wire

// File: bench/tick_priority_task_scheduler_test.sv
`timescale 1ns / 100ps
module tick_priority_task_scheduler_test;
  import tpts_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int STALL_PCT   = 9;
  localparam int WDOG_LIMIT  = 3000;
  localparam int SETTLE_CYC  = 20;
  localparam int TARGET_BEATS = 1050;

  typedef struct packed {
    res_t               flags;
    logic [LEVEL_W-1:0] level;
  } sched_res_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  period;
    logic [CNT_W-1:0]  first_delay;
    bit                typed;
    sched_res_t        want;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [KIND_W-1:0]  in_kind;
  logic [CNT_W-1:0]   in_period;
  logic [CNT_W-1:0]   in_first_delay;
  logic               out_valid;
  logic               out_stall;
  logic               out_add_ok;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_started;
  logic [SLOT_W-1:0]  out_start_task;
  logic               out_finished;
  logic [SLOT_W-1:0]  out_finished_task;
  logic               out_removed;
  logic               out_fault;
  logic [LEVEL_W-1:0] out_running_level;

  tick_priority_task_scheduler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_period         (in_period),
    .in_first_delay    (in_first_delay),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_add_ok        (out_add_ok),
    .out_slot          (out_slot),
    .out_started       (out_started),
    .out_start_task    (out_start_task),
    .out_finished      (out_finished),
    .out_finished_task (out_finished_task),
    .out_removed       (out_removed),
    .out_fault         (out_fault),
    .out_running_level (out_running_level)
  );

  // scheduler shadow state
  logic               live_q    [TASK_SLOTS];
  logic [CNT_W-1:0]   period_q  [TASK_SLOTS];
  logic [CNT_W-1:0]   count_q   [TASK_SLOTS];
  logic               pending_q [TASK_SLOTS];
  logic [LEVEL_W-1:0] saved_q   [TASK_SLOTS];
  logic [LEVEL_W-1:0] level_q;
  int                 depth_q;

  sched_res_t sched_results_due[$];
  plan_row_t  plan[$];

  bit calm;
  bit finishing;
  int errors;
  int out_beats;
  int wdog_cnt;
  int n_beats, n_adds, n_refused, n_ticks, n_dones, n_faults, n_noise;
  int n_starts, n_removed, max_depth;

  always #5 clk = ~clk;

  function automatic logic [SLOT_W:0] launch_pending();
    logic [SLOT_W:0] hit;
    hit = '0;
    if (depth_q < TASK_SLOTS) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (!hit[SLOT_W] && i < level_q && live_q[i] && pending_q[i]) begin
          pending_q[i] = 1'b0;
          saved_q[depth_q] = level_q;
          depth_q++;
          level_q = LEVEL_W'(i);
          hit = {1'b1, SLOT_W'(i)};
        end
      end
    end
    return hit;
  endfunction

  function automatic sched_res_t predict_sched(logic [KIND_W-1:0] kind,
                                               logic [CNT_W-1:0] per,
                                               logic [CNT_W-1:0] dly);
    sched_res_t      r;
    logic [SLOT_W:0] st;
    int              t;
    r  = '0;
    st = '0;
    case (kind)
      KIND_ADD: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (!live_q[i] && !r.flags.add_ok) begin
            live_q[i]    = 1'b1;
            period_q[i]  = per;
            count_q[i]   = dly;
            pending_q[i] = 1'b0;
            r.flags.add_ok = 1'b1;
            r.flags.slot   = SLOT_W'(i);
          end
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (live_q[i]) begin
            if (count_q[i] != '0) begin
              count_q[i] = count_q[i] - 1'b1;
            end else begin
              pending_q[i] = 1'b1;
              count_q[i] = (period_q[i] != '0) ? period_q[i] - 1'b1 : '0;
            end
          end
        end
        st = launch_pending();
      end
      KIND_DONE: begin
        if (depth_q == 0 || level_q >= IDLE_LVL) begin
          r.flags.fault = 1'b1;
        end else begin
          t = level_q;
          r.flags.finished      = 1'b1;
          r.flags.finished_task = SLOT_W'(t);
          depth_q--;
          level_q = saved_q[depth_q];
          if (level_q > IDLE_LVL) level_q = IDLE_LVL;
          if (period_q[t] == '0) begin
            live_q[t]    = 1'b0;
            pending_q[t] = 1'b0;
            r.flags.removed = 1'b1;
          end
          st = launch_pending();
        end
      end
      default: ;
    endcase
    r.flags.started    = st[SLOT_W];
    r.flags.start_task = st[SLOT_W-1:0];
    r.level            = level_q;
    return r;
  endfunction

  function automatic sched_res_t typed_res(bit ok, int slot, bit fault,
                                           logic [LEVEL_W-1:0] level);
    sched_res_t r;
    r = '0;
    r.flags.add_ok = ok;
    r.flags.slot   = SLOT_W'(slot);
    r.flags.fault  = fault;
    r.level        = level;
    return r;
  endfunction

  function automatic void plan_row(logic [KIND_W-1:0] kind, logic [CNT_W-1:0] per,
                                   logic [CNT_W-1:0] dly, bit typed, sched_res_t want);
    plan_row_t row;
    row.kind        = kind;
    row.period      = per;
    row.first_delay = dly;
    row.typed       = typed;
    row.want        = want;
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 40)
      $display("%0t: result %0d: %s is %0d, expected %0d", $realtime, out_beats, what,
               got, want);
  endtask

  // entered and left at a falling edge
  task automatic send_beat(logic [KIND_W-1:0] kind, logic [CNT_W-1:0] per,
                           logic [CNT_W-1:0] dly, bit typed, sched_res_t want);
    sched_res_t pr;
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_period      <= per;
    in_first_delay <= dly;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pr = predict_sched(kind, per, dly);
    sched_results_due.push_back(typed ? want : pr);
    n_beats++;
    case (kind)
      KIND_ADD:  begin n_adds++; if (!pr.flags.add_ok) n_refused++; end
      KIND_TICK: n_ticks++;
      KIND_DONE: begin n_dones++; if (pr.flags.fault) n_faults++; end
      default:   n_noise++;
    endcase
    if (pr.flags.started) n_starts++;
    if (pr.flags.removed) n_removed++;
    if (depth_q > max_depth) max_depth = depth_q;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sched_results_due.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(0, 99) < STALL_PCT);
  end

  always @(posedge clk) begin
    sched_res_t w;
    if (rst_n && out_valid && !out_stall) begin
      out_beats++;
      if (sched_results_due.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = sched_results_due.pop_front();
        if (out_add_ok !== w.flags.add_ok)
          report_mismatch("add_ok", out_add_ok, w.flags.add_ok);
        if (out_slot !== w.flags.slot)
          report_mismatch("slot", out_slot, w.flags.slot);
        if (out_started !== w.flags.started)
          report_mismatch("started", out_started, w.flags.started);
        if (out_start_task !== w.flags.start_task)
          report_mismatch("start_task", out_start_task, w.flags.start_task);
        if (out_finished !== w.flags.finished)
          report_mismatch("finished", out_finished, w.flags.finished);
        if (out_finished_task !== w.flags.finished_task)
          report_mismatch("finished_task", out_finished_task, w.flags.finished_task);
        if (out_removed !== w.flags.removed)
          report_mismatch("removed", out_removed, w.flags.removed);
        if (out_fault !== w.flags.fault)
          report_mismatch("fault", out_fault, w.flags.fault);
        if (out_running_level !== w.level)
          report_mismatch("running_level", out_running_level, w.level);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !finishing) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        wdog_cnt = 0;
      end else begin
        wdog_cnt++;
        if (wdog_cnt >= WDOG_LIMIT) begin
          $display("watchdog: no beat moved for %0d cycles", WDOG_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int                n;
    int                hogs;
    int                r;
    bit                full;
    logic [KIND_W-1:0] k;
    logic [CNT_W-1:0]  p;
    logic [CNT_W-1:0]  d;

    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_NONE;
    in_period      = '0;
    in_first_delay = '0;
    out_stall      = 1'b0;
    calm           = 1'b0;
    finishing      = 1'b0;
    errors         = 0;
    out_beats      = 0;
    wdog_cnt       = 0;
    n_beats = 0; n_adds = 0; n_refused = 0; n_ticks = 0; n_dones = 0;
    n_faults = 0; n_noise = 0; n_starts = 0; n_removed = 0; max_depth = 0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      live_q[i]    = 1'b0;
      pending_q[i] = 1'b0;
      period_q[i]  = '0;
      count_q[i]   = '0;
      saved_q[i]   = '0;
    end
    level_q = IDLE_LVL;
    depth_q = 0;

    // done while idle, ignored kind, empty tick, fill the table, then refuse
    plan_row(KIND_DONE, 16'h0000, 16'h0000, 1, typed_res(0, 0, 1, IDLE_LVL));
    plan_row(KIND_NONE, 16'hFFFF, 16'hFFFF, 1, typed_res(0, 0, 0, IDLE_LVL));
    plan_row(KIND_TICK, 16'h0000, 16'h0000, 1, typed_res(0, 0, 0, IDLE_LVL));
    plan_row(KIND_ADD,  16'h0000, 16'h0000, 1, typed_res(1, 0, 0, IDLE_LVL));
    plan_row(KIND_ADD,  16'hFFFF, 16'hFFFF, 1, typed_res(1, 1, 0, IDLE_LVL));
    plan_row(KIND_ADD,  16'h0003, 16'h0001, 1, typed_res(1, 2, 0, IDLE_LVL));
    plan_row(KIND_ADD,  16'h0001, 16'h0000, 1, typed_res(1, 3, 0, IDLE_LVL));
    plan_row(KIND_ADD,  16'h5555, 16'hAAAA, 1, typed_res(0, 0, 0, IDLE_LVL));
    // starts, zero-period repeats, nesting and one-shot removal
    plan_row(KIND_TICK, 16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_TICK, 16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_DONE, 16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_DONE, 16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_TICK, 16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_ADD,  16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_TICK, 16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_DONE, 16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_DONE, 16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_DONE, 16'h0000, 16'h0000, 0, '0);
    plan_row(KIND_DONE, 16'hAAAA, 16'h5555, 0, '0);
    plan_row(KIND_NONE, 16'h1234, 16'hFEDC, 0, '0);
    plan_row(KIND_TICK, 16'hFFFF, 16'hFFFF, 0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i])
      send_beat(plan[i].kind, plan[i].period, plan[i].first_delay, plan[i].typed,
                plan[i].want);
    drain_results();

    n = 0;
    while (n_beats - n_noise < TARGET_BEATS) begin
      calm = (n >= 400 && n < 600);
      if (n % 300 == 150) drain_results();
      hogs = 0;
      full = 1'b1;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (live_q[i] && (period_q[i] != '0 || count_q[i] > 16)) hogs++;
        if (!live_q[i]) full = 1'b0;
      end
      p = $urandom;
      d = $urandom;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        k = KIND_NONE;
      end else if (r < 26) begin
        k = KIND_ADD;
        if (!full) begin
          r = $urandom_range(0, 9);
          if (hogs >= 2 || r < 6) p = '0;
          else if (r < 9) p = CNT_W'($urandom_range(1, 8));
          if (hogs >= 2 || $urandom_range(0, 19) != 0) d = CNT_W'($urandom_range(0, 6));
        end
      end else if (r < 64) begin
        k = KIND_TICK;
      end else begin
        k = (depth_q == 0 && $urandom_range(0, 3) != 0) ? KIND_TICK : KIND_DONE;
      end
      send_beat(k, p, d, 0, '0);
      n++;
    end
    calm = 1'b0;

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);
    finishing = 1'b1;
    $display("%0d beats in: %0d adds (%0d refused), %0d ticks, %0d dones (%0d idle), %0d noise",
             n_beats, n_adds, n_refused, n_ticks, n_dones, n_faults, n_noise);
    $display("%0d task starts, %0d one-shot removals, preemption up to %0d deep",
             n_starts, n_removed, max_depth);
    if (errors == 0 && sched_results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, sched_results_due.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
